@@ rtl/vector3_arithmetic_unit_macros.svh @@
// Assertion macros used by the checker file of the vector unit.
`ifndef VECTOR3_ARITHMETIC_UNIT_MACROS_SVH
`define VECTOR3_ARITHMETIC_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define VAU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define VAU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/vau_pkg.sv @@
// Package of the vector unit: action codes, widths and beat types.
`timescale 1ns / 1ps
package vau_pkg;

    // Action codes
    localparam logic [3:0] ACT_ADD     = 4'd0;
    localparam logic [3:0] ACT_SUB     = 4'd1;
    localparam logic [3:0] ACT_SCALE   = 4'd2;
    localparam logic [3:0] ACT_DOT     = 4'd3;
    localparam logic [3:0] ACT_CROSS   = 4'd4;
    localparam logic [3:0] ACT_MAG     = 4'd5;
    localparam logic [3:0] ACT_UNIT    = 4'd6;
    localparam logic [3:0] ACT_PSCALAR = 4'd7;
    localparam logic [3:0] ACT_PROJ    = 4'd8;

    // One square-root cell per root bit, one divide cell per quotient bit
    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 33;

    typedef struct packed {
        logic [3:0]         action;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] scale_factor;
    } t_vau_in;

    typedef struct packed {
        logic signed [31:0] res_x;
        logic signed [31:0] res_y;
        logic signed [31:0] res_z;
        logic               overflow;
        logic               zero_length;
    } t_vau_out;

    // Per-item context that rides along the cell chains
    typedef struct packed {
        logic [3:0]       action;
        logic [2:0][31:0] res;     // finished result for non-divide actions
        logic             ovf;
        logic             zero_s;  // |A|^2 is zero
        logic [2:0]       sgn;     // sign of each divide lane
    } t_side;

    // Square-root chain data
    typedef struct packed {
        logic [63:0]      rad;     // radicand, consumed two bits per cell
        logic [63:0]      s;       // |A|^2 kept whole for the divisor
        logic [33:0]      rem;
        logic [31:0]      root;
        logic [2:0][95:0] num;     // dividends of the three lanes
        t_side            side;
    } t_sq_data;

    // Divide chain data
    typedef struct packed {
        logic [63:0]      d;
        logic [2:0][63:0] rem;
        logic [2:0][32:0] low;     // dividend bits still to shift in
        logic [2:0][32:0] quo;
        logic [2:0]       big;     // quotient does not fit in 33 bits
        t_side            side;
    } t_div_data;

endpackage

@@ rtl/vau_stream_if.sv @@
// Valid/ready stream interface used for the input and result channels.
`timescale 1ns / 1ps
interface vau_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/vau_sqrt_cell.sv @@
// One square-root cell: retires one root bit and hands the item on.
`timescale 1ns / 1ps
module vau_sqrt_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  vau_pkg::t_sq_data  i_data,
    output logic               o_valid,
    output vau_pkg::t_sq_data  o_data
);

    logic              r_valid;
    vau_pkg::t_sq_data r_data;
    vau_pkg::t_sq_data n_data;
    logic [35:0]       rem_sh;
    logic [35:0]       trial;

    // Bring in the next radicand pair and try the next root bit
    always_comb begin
        n_data     = i_data;
        rem_sh     = {i_data.rem, i_data.rad[63:62]};
        trial      = {2'b00, i_data.root, 2'b01};
        n_data.rad = {i_data.rad[61:0], 2'b00};
        if (rem_sh >= trial) begin
            n_data.rem  = 34'(rem_sh - trial);
            n_data.root = {i_data.root[30:0], 1'b1};
        end else begin
            n_data.rem  = rem_sh[33:0];
            n_data.root = {i_data.root[30:0], 1'b0};
        end
    end

    // Advance the cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ rtl/vau_div_cell.sv @@
// One divide cell: retires one quotient bit in each of three lanes.
`timescale 1ns / 1ps
module vau_div_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  vau_pkg::t_div_data i_data,
    output logic               o_valid,
    output vau_pkg::t_div_data o_data
);

    logic               r_valid;
    vau_pkg::t_div_data r_data;
    vau_pkg::t_div_data n_data;
    logic [64:0]        rem_sh [3];
    logic [64:0]        dvs;

    // Shift in one dividend bit per lane, subtract the divisor where it fits
    always_comb begin
        n_data = i_data;
        dvs    = {1'b0, i_data.d};
        for (int l = 0; l < 3; l++) begin
            rem_sh[l]     = {i_data.rem[l], i_data.low[l][32]};
            n_data.low[l] = {i_data.low[l][31:0], 1'b0};
            if (rem_sh[l] >= dvs) begin
                n_data.rem[l] = 64'(rem_sh[l] - dvs);
                n_data.quo[l] = {i_data.quo[l][31:0], 1'b1};
            end else begin
                n_data.rem[l] = rem_sh[l][63:0];
                n_data.quo[l] = {i_data.quo[l][31:0], 1'b0};
            end
        end
    end

    // Advance the cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ rtl/vector3_arithmetic_unit.sv @@
// Top level of the pipelined 3D vector unit over signed fixed-point words.
// Usage:
//   i_in carries one beat per operation: action, vectors A and B and the
//   scale factor. o_res returns one beat per operation, in order: three
//   components (scalars in res_x), overflow and zero_length flags.
//   Both channels move a beat when valid and ready are high at a clock edge.
// Path: a beat taken from i_in passes five front stages (input register,
//   products, sums, dot-magnitude products, dividends), 32 square-root
//   cells (one root bit each), one divisor set-up stage and 33 divide
//   cells (one quotient bit each); its result then enters the output buffer.
// Throughput: one beat per cycle while the output buffer has room; every stage
//   is a register and all advance together, held only while i_in.ready is low.
// Stall: results land in a two-entry output buffer. The pipeline and i_in
//   keep moving while one result waits; only with two waiting results does
//   i_in.ready drop and the whole chain hold.
// Reset: i_rst_n low for one clock empties the pipeline and the buffer;
//   there is no other state and no clearing pass.
`timescale 1ns / 1ps
module vector3_arithmetic_unit #(
    parameter int FRAC_BITS = 16
) (
    input logic         i_clk,
    input logic         i_rst_n,
    vau_stream_if.sink   i_in,
    vau_stream_if.source o_res
);

    localparam logic signed [66:0] SAT_HI = 67'sd2147483647;
    localparam logic signed [66:0] SAT_LO = -67'sd2147483648;

    // Saturate a wide signed value to 32 bits; top bit flags saturation
    function automatic logic [32:0] sat32(input logic signed [66:0] v);
        logic [32:0] r;
        if (v > SAT_HI) begin
            r = {1'b1, 32'h7FFF_FFFF};
        end else if (v < SAT_LO) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

    logic en;

    // Stage 1: input register
    logic             r1_v;
    vau_pkg::t_vau_in r1_d;

    // Stage 2: products
    logic signed [31:0] a_v [3];
    logic signed [31:0] b_v [3];
    logic signed [31:0] mx [6];
    logic signed [31:0] my [6];
    logic signed [63:0] n2_sq [3];
    logic signed [63:0] n2_dp [3];
    logic signed [63:0] n2_xp [6];
    logic signed [32:0] n2_as [3];
    logic [31:0]        n2_aabs [3];
    logic [2:0]         n2_aneg;

    logic               r2_v;
    logic [3:0]         r2_act;
    logic [63:0]        r2_sq [3];
    logic signed [63:0] r2_dp [3];
    logic signed [63:0] r2_xp [6];
    logic signed [32:0] r2_as [3];
    logic [31:0]        r2_aabs [3];
    logic [2:0]         r2_aneg;

    // Stage 3: sums and finished simple results
    logic [63:0]         s_sum;
    logic signed [65:0]  dot;
    logic                dneg;
    logic [63:0]         n3_dmag;
    logic signed [64:0]  xv [3];
    logic [32:0]         st [3];
    vau_pkg::t_side      n3_side;

    logic           r3_v;
    vau_pkg::t_side r3_side;
    logic [63:0]    r3_s;
    logic [63:0]    r3_dmag;
    logic [31:0]    r3_aabs [3];

    // Stage 4: dot magnitude times |a_i| in two halves
    logic           r4_v;
    vau_pkg::t_side r4_side;
    logic [63:0]    r4_s;
    logic [63:0]    r4_dmag;
    logic [31:0]    r4_aabs [3];
    logic [63:0]    r4_plo [3];
    logic [63:0]    r4_phi [3];

    // Stage 5: dividends
    logic [2:0][95:0] n5_num;
    logic             r5_v;
    vau_pkg::t_side   r5_side;
    logic [63:0]      r5_s;
    logic [2:0][95:0] r5_num;

    // Square-root chain
    logic              sq_v [vau_pkg::SQ_STEPS+1];
    vau_pkg::t_sq_data sq_d [vau_pkg::SQ_STEPS+1];

    // Divisor set-up stage
    vau_pkg::t_div_data n6_d;
    logic               r6_v;
    vau_pkg::t_div_data r6_d;

    // Divide chain
    logic               dv_v [vau_pkg::DIV_STEPS+1];
    vau_pkg::t_div_data dv_d [vau_pkg::DIV_STEPS+1];

    // Final result and output buffer
    logic [31:0]       lval [3];
    logic [2:0]        lover;
    logic              is_div;
    vau_pkg::t_vau_out fin;
    logic              push;
    logic              pop;
    vau_pkg::t_vau_out r_mem [2];
    logic              r_wp;
    logic              r_rp;
    logic [1:0]        r_cnt;
    logic [1:0]        n_cnt;

    // Hold the whole chain only when the output buffer is full
    assign en         = (r_cnt != 2'd2);
    assign i_in.ready = en;

    // Products, add/sub and operand selection
    always_comb begin
        a_v[0] = r1_d.a_x;
        a_v[1] = r1_d.a_y;
        a_v[2] = r1_d.a_z;
        b_v[0] = r1_d.b_x;
        b_v[1] = r1_d.b_y;
        b_v[2] = r1_d.b_z;
        for (int i = 0; i < 3; i++) begin
            if (r1_d.action == vau_pkg::ACT_SCALE) begin
                mx[2*i]   = a_v[i];
                my[2*i]   = r1_d.scale_factor;
                mx[2*i+1] = '0;
                my[2*i+1] = '0;
            end else begin
                mx[2*i]   = a_v[(i+1)%3];
                my[2*i]   = b_v[(i+2)%3];
                mx[2*i+1] = a_v[(i+2)%3];
                my[2*i+1] = b_v[(i+1)%3];
            end
        end
        for (int m = 0; m < 6; m++) begin
            n2_xp[m] = mx[m] * my[m];
        end
        for (int i = 0; i < 3; i++) begin
            n2_sq[i]   = a_v[i] * a_v[i];
            n2_dp[i]   = a_v[i] * b_v[i];
            n2_as[i]   = (r1_d.action == vau_pkg::ACT_SUB) ?
                         (33'(a_v[i]) - 33'(b_v[i])) : (33'(a_v[i]) + 33'(b_v[i]));
            n2_aabs[i] = a_v[i][31] ? 32'(-a_v[i]) : 32'(a_v[i]);
            n2_aneg[i] = a_v[i][31];
        end
    end

    // Sums, arithmetic shift and saturation of the simple actions
    always_comb begin
        s_sum   = r2_sq[0] + r2_sq[1] + r2_sq[2];
        dot     = 66'(r2_dp[0]) + 66'(r2_dp[1]) + 66'(r2_dp[2]);
        dneg    = dot[65];
        n3_dmag = dneg ? 64'(-dot) : dot[63:0];
        for (int i = 0; i < 3; i++) begin
            xv[i] = 65'(r2_xp[2*i]) - 65'(r2_xp[2*i+1]);
            st[i] = '0;
        end
        unique case (r2_act)
            vau_pkg::ACT_ADD, vau_pkg::ACT_SUB: begin
                for (int i = 0; i < 3; i++) begin
                    st[i] = sat32(67'(r2_as[i]));
                end
            end
            vau_pkg::ACT_SCALE, vau_pkg::ACT_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    st[i] = sat32(67'(xv[i]) >>> FRAC_BITS);
                end
            end
            vau_pkg::ACT_DOT: begin
                st[0] = sat32(67'(dot) >>> FRAC_BITS);
            end
            default: begin
                st[0] = '0;
            end
        endcase
        n3_side.action = r2_act;
        n3_side.zero_s = (s_sum == 64'd0);
        n3_side.ovf    = st[0][32] | st[1][32] | st[2][32];
        for (int i = 0; i < 3; i++) begin
            n3_side.res[i] = st[i][31:0];
        end
        unique case (r2_act)
            vau_pkg::ACT_UNIT:    n3_side.sgn = r2_aneg;
            vau_pkg::ACT_PSCALAR: n3_side.sgn = {2'b00, dneg};
            vau_pkg::ACT_PROJ:    n3_side.sgn = r2_aneg ^ {3{dneg}};
            default:              n3_side.sgn = 3'b000;
        endcase
    end

    // Dividends of the three lanes
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            unique case (r4_side.action)
                vau_pkg::ACT_UNIT:
                    n5_num[l] = 96'(r4_aabs[l]) << FRAC_BITS;
                vau_pkg::ACT_PSCALAR:
                    n5_num[l] = (l == 0) ? (96'(r4_dmag) << FRAC_BITS) : 96'd0;
                vau_pkg::ACT_PROJ:
                    n5_num[l] = 96'(r4_plo[l]) + (96'(r4_phi[l]) << 32);
                default:
                    n5_num[l] = 96'd0;
            endcase
        end
    end

    // Valid bits of the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_in.valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= sq_v[vau_pkg::SQ_STEPS];
        end
    end

    // Payload of the front stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_d    <= i_in.data;
            r2_act  <= r1_d.action;
            r2_aneg <= n2_aneg;
            for (int i = 0; i < 3; i++) begin
                r2_sq[i]   <= n2_sq[i];
                r2_dp[i]   <= n2_dp[i];
                r2_as[i]   <= n2_as[i];
                r2_aabs[i] <= n2_aabs[i];
            end
            for (int m = 0; m < 6; m++) begin
                r2_xp[m] <= n2_xp[m];
            end
            r3_side <= n3_side;
            r3_s    <= s_sum;
            r3_dmag <= n3_dmag;
            r4_side <= r3_side;
            r4_s    <= r3_s;
            r4_dmag <= r3_dmag;
            for (int i = 0; i < 3; i++) begin
                r3_aabs[i] <= r2_aabs[i];
                r4_aabs[i] <= r3_aabs[i];
                r4_plo[i]  <= r3_dmag[31:0] * r3_aabs[i];
                r4_phi[i]  <= r3_dmag[63:32] * r3_aabs[i];
            end
            r5_side <= r4_side;
            r5_s    <= r4_s;
            r5_num  <= n5_num;
            r6_d    <= n6_d;
        end
    end

    // Square-root chain
    always_comb begin
        sq_v[0]      = r5_v;
        sq_d[0].rad  = r5_s;
        sq_d[0].s    = r5_s;
        sq_d[0].rem  = '0;
        sq_d[0].root = '0;
        sq_d[0].num  = r5_num;
        sq_d[0].side = r5_side;
    end

    for (genvar g = 0; g < vau_pkg::SQ_STEPS; g++) begin : g_sqrt
        vau_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_v[g]),
            .i_data  (sq_d[g]),
            .o_valid (sq_v[g+1]),
            .o_data  (sq_d[g+1])
        );
    end

    // Pick the divisor, finish magnitude, flag quotients that overflow
    always_comb begin
        n6_d.side = sq_d[vau_pkg::SQ_STEPS].side;
        n6_d.d    = (sq_d[vau_pkg::SQ_STEPS].side.action == vau_pkg::ACT_UNIT) ?
                    {32'd0, sq_d[vau_pkg::SQ_STEPS].root} : sq_d[vau_pkg::SQ_STEPS].s;
        if (sq_d[vau_pkg::SQ_STEPS].side.action == vau_pkg::ACT_MAG) begin
            n6_d.side.ovf    = sq_d[vau_pkg::SQ_STEPS].root[31];
            n6_d.side.res[0] = sq_d[vau_pkg::SQ_STEPS].root[31] ?
                               32'h7FFF_FFFF : sq_d[vau_pkg::SQ_STEPS].root;
        end
        for (int l = 0; l < 3; l++) begin
            n6_d.rem[l] = {1'b0, sq_d[vau_pkg::SQ_STEPS].num[l][95:33]};
            n6_d.low[l] = sq_d[vau_pkg::SQ_STEPS].num[l][32:0];
            n6_d.quo[l] = '0;
            n6_d.big[l] = ({1'b0, sq_d[vau_pkg::SQ_STEPS].num[l][95:33]} >= n6_d.d);
        end
    end

    // Divide chain
    assign dv_v[0] = r6_v;
    assign dv_d[0] = r6_d;

    for (genvar g = 0; g < vau_pkg::DIV_STEPS; g++) begin : g_div
        vau_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv_v[g]),
            .i_data  (dv_d[g]),
            .o_valid (dv_v[g+1]),
            .o_data  (dv_d[g+1])
        );
    end

    // Apply signs, saturate quotients and select the final result
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            if (dv_d[vau_pkg::DIV_STEPS].side.sgn[l]) begin
                lover[l] = dv_d[vau_pkg::DIV_STEPS].big[l] |
                           (dv_d[vau_pkg::DIV_STEPS].quo[l] > 33'h0_8000_0000);
                lval[l]  = lover[l] ? 32'h8000_0000 :
                           32'(-dv_d[vau_pkg::DIV_STEPS].quo[l]);
            end else begin
                lover[l] = dv_d[vau_pkg::DIV_STEPS].big[l] |
                           (dv_d[vau_pkg::DIV_STEPS].quo[l] > 33'h0_7FFF_FFFF);
                lval[l]  = lover[l] ? 32'h7FFF_FFFF :
                           dv_d[vau_pkg::DIV_STEPS].quo[l][31:0];
            end
        end
        is_div = (dv_d[vau_pkg::DIV_STEPS].side.action == vau_pkg::ACT_UNIT) ||
                 (dv_d[vau_pkg::DIV_STEPS].side.action == vau_pkg::ACT_PSCALAR) ||
                 (dv_d[vau_pkg::DIV_STEPS].side.action == vau_pkg::ACT_PROJ);
        if (is_div && dv_d[vau_pkg::DIV_STEPS].side.zero_s) begin
            fin.res_x       = '0;
            fin.res_y       = '0;
            fin.res_z       = '0;
            fin.overflow    = 1'b0;
            fin.zero_length = 1'b1;
        end else if (is_div) begin
            fin.res_x       = lval[0];
            fin.res_y       = lval[1];
            fin.res_z       = lval[2];
            fin.overflow    = |lover;
            fin.zero_length = 1'b0;
        end else begin
            fin.res_x       = dv_d[vau_pkg::DIV_STEPS].side.res[0];
            fin.res_y       = dv_d[vau_pkg::DIV_STEPS].side.res[1];
            fin.res_z       = dv_d[vau_pkg::DIV_STEPS].side.res[2];
            fin.overflow    = dv_d[vau_pkg::DIV_STEPS].side.ovf;
            fin.zero_length = 1'b0;
        end
    end

    // Output buffer: two entries, fed by the end of the divide chain
    assign push        = dv_v[vau_pkg::DIV_STEPS] && en;
    assign pop         = o_res.valid && o_res.ready;
    assign o_res.valid = (r_cnt != 2'd0);
    assign o_res.data  = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= fin;
        end
    end

endmodule

@@ rtl/vau_checker.sv @@
// Port-level checker of the vector unit and its bind to the top level.
`timescale 1ns / 1ps
`include "vector3_arithmetic_unit_macros.svh"
module vau_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input vau_pkg::t_vau_out i_out_data
);

    logic sat_seen;
    logic all_zero;

    // Some component sits at a saturation limit
    assign sat_seen = (i_out_data.res_x == 32'sh7FFF_FFFF) ||
                      (i_out_data.res_x == 32'sh8000_0000) ||
                      (i_out_data.res_y == 32'sh7FFF_FFFF) ||
                      (i_out_data.res_y == 32'sh8000_0000) ||
                      (i_out_data.res_z == 32'sh7FFF_FFFF) ||
                      (i_out_data.res_z == 32'sh8000_0000);

    assign all_zero = (i_out_data.res_x == 32'sd0) && (i_out_data.res_y == 32'sd0) &&
                      (i_out_data.res_z == 32'sd0);

    `VAU_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data), "result beat changed while stalled")
    `VAU_ASSERT_SAME(a_zero_len_clean, i_out_valid && i_out_data.zero_length, all_zero && !i_out_data.overflow, "zero-length result not cleared")
    `VAU_ASSERT_SAME(a_ovf_saturates, i_out_valid && i_out_data.overflow, sat_seen, "overflow without a saturated component")
    `VAU_ASSERT_SAME(a_stall_cause, !i_in_ready, i_out_valid, "input stalled with no result waiting")
    `VAU_ASSERT_NEXT(a_room_after_pop, i_out_valid && i_out_ready && !i_in_valid, i_in_ready, "no room after a result beat left")

endmodule

bind vector3_arithmetic_unit vau_checker u_vau_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);

@@ tb/tb.sv @@
// Self-checking testbench for the pipelined 3D vector unit.
`timescale 1ns / 1ps
module tb;
    import vau_pkg::*;

    localparam int FRAC = 16;
    localparam logic signed [129:0] Q_MAX = 130'sd2147483647;
    localparam logic signed [129:0] Q_MIN = -130'sd2147483648;

    logic i_clk;
    logic i_rst_n;

    vau_stream_if #(.T(t_vau_in))  in_if ();
    vau_stream_if #(.T(t_vau_out)) res_if ();

    vector3_arithmetic_unit #(.FRAC_BITS(FRAC)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_res   (res_if)
    );

    t_vau_in  op_pending[$];
    t_vau_out result_expected[$];
    int       src_idle_pct;
    int       snk_stall_pct;
    logic     in_took;
    int       mismatch_cnt;

    // Free-running clock, 2 ns period
    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Saturate a wide signed value to a 32-bit word; bit 32 flags overflow
    function automatic logic [32:0] clamp_word(input logic signed [129:0] v);
        if (v > Q_MAX) return {1'b1, 32'h7FFF_FFFF};
        if (v < Q_MIN) return {1'b1, 32'h8000_0000};
        return {1'b0, v[31:0]};
    endfunction

    function automatic logic signed [129:0] apply_sign(input logic [127:0] m, input logic neg);
        logic signed [129:0] sv;
        sv = $signed({2'b00, m});
        return neg ? -sv : sv;
    endfunction

    // Floor of the square root of a 64-bit value, one root bit per pass
    function automatic logic [63:0] floor_sqrt(input logic [63:0] s);
        logic [63:0] root;
        logic [63:0] trial;
        logic [127:0] sq;
        root = '0;
        for (int i = 31; i >= 0; i--) begin
            trial = root | (64'd1 << i);
            sq = trial * trial;
            if (sq <= {64'd0, s}) root = trial;
        end
        return root;
    endfunction

    // Compute the expected result beat of one operation
    function automatic t_vau_out vector_op_result(input t_vau_in x);
        logic signed [63:0]  a[3];
        logic signed [63:0]  b[3];
        logic signed [63:0]  sf;
        logic signed [129:0] v;
        logic signed [129:0] dsum;
        logic [127:0]        sq_len;
        logic [127:0]        dmag;
        logic [127:0]        absa;
        logic [127:0]        quo;
        logic [63:0]         len;
        logic                dneg;
        logic [32:0]         cw;
        logic [31:0]         w[3];
        logic                ovf;
        t_vau_out            r;
        int                  j;
        int                  k;
        a[0] = x.a_x; a[1] = x.a_y; a[2] = x.a_z;
        b[0] = x.b_x; b[1] = x.b_y; b[2] = x.b_z;
        sf = x.scale_factor;
        w[0] = '0; w[1] = '0; w[2] = '0;
        ovf = 1'b0;
        r = '0;
        sq_len = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        dsum = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        dneg = dsum < 0;
        dmag = dneg ? -dsum : dsum;
        case (x.action)
            ACT_ADD, ACT_SUB, ACT_SCALE, ACT_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    j = (i + 1) % 3;
                    k = (i + 2) % 3;
                    if (x.action == ACT_ADD) v = a[i] + b[i];
                    else if (x.action == ACT_SUB) v = a[i] - b[i];
                    else if (x.action == ACT_SCALE) v = (a[i] * sf) >>> FRAC;
                    else v = (a[j] * b[k] - a[k] * b[j]) >>> FRAC;
                    cw = clamp_word(v);
                    w[i] = cw[31:0];
                    ovf |= cw[32];
                end
            end
            ACT_DOT: begin
                cw = clamp_word(dsum >>> FRAC);
                w[0] = cw[31:0];
                ovf = cw[32];
            end
            ACT_MAG: begin
                len = floor_sqrt(sq_len[63:0]);
                v = $signed({66'd0, len});
                cw = clamp_word(v);
                w[0] = cw[31:0];
                ovf = cw[32];
            end
            ACT_UNIT, ACT_PSCALAR, ACT_PROJ: begin
                if (sq_len == 0) begin
                    r.zero_length = 1'b1;
                end else if (x.action == ACT_PSCALAR) begin
                    quo = (dmag << FRAC) / sq_len;
                    cw = clamp_word(apply_sign(quo, dneg));
                    w[0] = cw[31:0];
                    ovf = cw[32];
                end else begin
                    len = floor_sqrt(sq_len[63:0]);
                    for (int i = 0; i < 3; i++) begin
                        absa = (a[i] < 0) ? -a[i] : a[i];
                        if (x.action == ACT_UNIT) begin
                            quo = (absa << FRAC) / {64'd0, len};
                            cw = clamp_word(apply_sign(quo, a[i] < 0));
                        end else begin
                            quo = (dmag * absa) / sq_len;
                            cw = clamp_word(apply_sign(quo, dneg != (a[i] < 0)));
                        end
                        w[i] = cw[31:0];
                        ovf |= cw[32];
                    end
                end
            end
            default: ;
        endcase
        r.res_x = w[0];
        r.res_y = w[1];
        r.res_z = w[2];
        r.overflow = ovf;
        return r;
    endfunction

    function automatic t_vau_in make_op(input logic [3:0] act,
                                        input logic [31:0] ax, input logic [31:0] ay,
                                        input logic [31:0] az, input logic [31:0] bx,
                                        input logic [31:0] by, input logic [31:0] bz,
                                        input logic [31:0] sf);
        t_vau_in t;
        t.action = act;
        t.a_x = ax; t.a_y = ay; t.a_z = az;
        t.b_x = bx; t.b_y = by; t.b_z = bz;
        t.scale_factor = sf;
        return t;
    endfunction

    // Mix of full-range, extreme and modest fixed-point values
    function automatic logic [31:0] rand_fixed();
        logic [31:0] extremes[5];
        extremes = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1, 32'hFFFF_FFFF};
        case ($urandom_range(0, 9))
            0, 1:    return $urandom;
            2:       return extremes[$urandom_range(0, 4)];
            3, 4, 5: return $urandom_range(0, 32'h007F_FFFF) - 32'h0040_0000;
            default: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
        endcase
    endfunction

    function automatic t_vau_in rand_op();
        t_vau_in t;
        t = make_op(($urandom_range(0, 19) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8),
                    rand_fixed(), rand_fixed(), rand_fixed(),
                    rand_fixed(), rand_fixed(), rand_fixed(), rand_fixed());
        // Zero-length A now and then for the divide actions
        if (t.action >= ACT_UNIT && t.action <= ACT_PROJ && $urandom_range(0, 9) == 0) begin
            t.a_x = '0; t.a_y = '0; t.a_z = '0;
        end
        return t;
    endfunction

    // Drive input beats and the result ready at the falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!in_if.valid || in_took) begin
                if (op_pending.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    in_if.data  <= op_pending.pop_front();
                    in_if.valid <= 1'b1;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
            res_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    // Record accepted operations and check result beats at the rising edge
    always @(posedge i_clk) begin
        t_vau_out want;
        t_vau_out got;
        in_took <= in_if.valid && in_if.ready;
        if (i_rst_n && in_if.valid && in_if.ready)
            result_expected.push_back(vector_op_result(in_if.data));
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got = res_if.data;
            if (result_expected.size() == 0) begin
                mismatch_cnt <= mismatch_cnt + 1;
                if (mismatch_cnt < 10)
                    $display("unexpected result beat %h %h %h ovf=%b zl=%b",
                             got.res_x, got.res_y, got.res_z, got.overflow, got.zero_length);
            end else begin
                want = result_expected.pop_front();
                if (got.res_x !== want.res_x || got.res_y !== want.res_y ||
                    got.res_z !== want.res_z || got.overflow !== want.overflow ||
                    got.zero_length !== want.zero_length) begin
                    mismatch_cnt <= mismatch_cnt + 1;
                    if (mismatch_cnt < 10)
                        $display("mismatch: exp %h %h %h ovf=%b zl=%b, got %h %h %h ovf=%b zl=%b",
                                 want.res_x, want.res_y, want.res_z, want.overflow,
                                 want.zero_length, got.res_x, got.res_y, got.res_z,
                                 got.overflow, got.zero_length);
                end
            end
        end
    end

    // Hold the run until every queued beat has gone and every result is back
    task automatic drain_all();
        while (op_pending.size() > 0 || in_if.valid || result_expected.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        int idle_tbl[4];
        int stall_tbl[4];
        idle_tbl  = '{0, 50, 0, 11};
        stall_tbl = '{0, 0, 50, 11};
        in_if.valid = 1'b0;
        in_if.data = '0;
        res_if.ready = 1'b0;
        in_took = 1'b0;
        mismatch_cnt = 0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes, every action, zero-length A, undefined codes
        op_pending.push_back(make_op(ACT_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1,
                                     32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0));
        op_pending.push_back(make_op(ACT_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                                     32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0));
        op_pending.push_back(make_op(ACT_SCALE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_8000,
                                     0, 0, 0, 32'h7FFF_FFFF));
        op_pending.push_back(make_op(ACT_SCALE, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0003_0000,
                                     0, 0, 0, 32'hFFFF_0000));
        op_pending.push_back(make_op(ACT_SCALE, 32'h8000_0000, 32'h1, 32'h2,
                                     0, 0, 0, 32'h8000_0000));
        op_pending.push_back(make_op(ACT_DOT, 32'h0000_0001, 32'h0, 32'h0,
                                     32'hFFFF_FFFF, 32'h0, 32'h0, 0));
        op_pending.push_back(make_op(ACT_DOT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
        op_pending.push_back(make_op(ACT_DOT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
        op_pending.push_back(make_op(ACT_CROSS, 32'h0001_0000, 32'h0, 32'h0,
                                     32'h0, 32'h0001_0000, 32'h0, 0));
        op_pending.push_back(make_op(ACT_CROSS, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                     32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0));
        op_pending.push_back(make_op(ACT_MAG, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                     0, 0, 0, 0));
        op_pending.push_back(make_op(ACT_MAG, 0, 0, 0, 0, 0, 0, 0));
        op_pending.push_back(make_op(ACT_MAG, 32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 0));
        op_pending.push_back(make_op(ACT_UNIT, 0, 0, 0, 32'h1234, 0, 0, 0));
        op_pending.push_back(make_op(ACT_UNIT, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0));
        op_pending.push_back(make_op(ACT_UNIT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 0, 0, 0, 0));
        op_pending.push_back(make_op(ACT_PSCALAR, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0));
        op_pending.push_back(make_op(ACT_PSCALAR, 32'h1, 0, 0,
                                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
        op_pending.push_back(make_op(ACT_PSCALAR, 32'h0002_0000, 32'h0, 32'h0,
                                     32'hFFFF_0000, 32'h5, 32'h5, 0));
        op_pending.push_back(make_op(ACT_PROJ, 0, 0, 0, 32'h1, 32'h1, 32'h1, 0));
        op_pending.push_back(make_op(ACT_PROJ, 32'h1, 32'hFFFF_FFFF, 0,
                                     32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0));
        op_pending.push_back(make_op(ACT_PROJ, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                                     32'h0002_0000, 32'hFFFF_0000, 32'h0000_8000, 0));
        op_pending.push_back(make_op(4'd9, 32'h7FFF_FFFF, 1, 1, 1, 1, 1, 1));
        op_pending.push_back(make_op(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                     32'hFFFF_FFFF));
        // Wait until every directed beat has gone and every result is back
        drain_all();

        // Random phases with different idle and stall rates
        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct = idle_tbl[ph];
            snk_stall_pct = stall_tbl[ph];
            for (int n = 0; n < 350; n++) op_pending.push_back(rand_op());
            drain_all();
        end

        repeat (100) @(posedge i_clk);
        if (mismatch_cnt == 0 && result_expected.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Timeout guard
    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ vector3_arithmetic_unit.f @@
+incdir+rtl
rtl/vau_pkg.sv
rtl/vau_stream_if.sv
rtl/vau_sqrt_cell.sv
rtl/vau_div_cell.sv
rtl/vector3_arithmetic_unit.sv
rtl/vau_checker.sv
tb/tb.sv
